### hw/rtl/lsfl_pkg.sv
package lsfl_pkg;

   localparam int UND_ENTRIES_DEF  = 16;
   localparam int QUAD_ENTRIES_DEF = 16;
   localparam int POS_WIDTH_DEF    = 32;

   // doubled positions: z2 < 2^41, window end z2 + dz < 2^42
   localparam int ZW       = 42;
   localparam int ACC_W    = 106;
   localparam int TAPER_SH = 41;

   localparam logic [1:0] OP_WR_UND  = 2'd0;
   localparam logic [1:0] OP_WR_QUAD = 2'd1;
   localparam logic [1:0] OP_EVAL    = 2'd2;
   localparam logic [1:0] OP_IGNORED = 2'd3;

   localparam int FLAG_NOCUR = 0;
   localparam int FLAG_AIR   = 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ZMUL,
      ST_ZCAP,
      ST_USCAN,
      ST_KMAG,
      ST_KMAGCAP,
      ST_KPP,
      ST_KFIN,
      ST_QSCAN,
      ST_QLEN,
      ST_GMUL,
      ST_GCAP,
      ST_GDIV,
      ST_GSIGN,
      ST_DONE
   } state_type;

   // doubled length units
   function automatic logic [ZW-1:0] dbl(input logic [31:0] v);
      dbl = {{(ZW-33){1'b0}}, v, 1'b0};
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

### hw/rtl/lsfl_req_if.sv
interface lsfl_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [3:0]         entry_index;
   logic [31:0]        seg_start;
   logic [31:0]        seg_end;
   logic [31:0]        cell_start;
   logic [31:0]        cell_end;
   logic signed [31:0] strength;
   logic signed [31:0] taper;
   logic               no_current;
   logic               air_gap;
   logic [23:0]        step_count;
   logic               half_step;

   modport source (output valid, opcode, entry_index, seg_start, seg_end, cell_start,
                   cell_end, strength, taper, no_current, air_gap, step_count,
                   half_step, input ready);
   modport sink (input valid, opcode, entry_index, seg_start, seg_end, cell_start,
                 cell_end, strength, taper, no_current, air_gap, step_count,
                 half_step, output ready);
endinterface

### hw/rtl/lsfl_rsp_if.sv
interface lsfl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] k_value;
   logic               current_on;
   logic signed [31:0] quad_gradient;

   modport source (output valid, k_value, current_on, quad_gradient, input ready);
   modport sink (input valid, k_value, current_on, quad_gradient, output ready);
endinterface

### hw/rtl/lsfl_mul.sv
module lsfl_mul
   import lsfl_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] prod_ff
);

   logic [63:0] prod_in;

   assign prod_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### hw/rtl/lattice_segment_field_lookup.sv
// Channel | Dir | Handshake              | Contents
// req_ch  | in  | valid/ready            | opcode, table entry or evaluation step
// rsp_ch  | out | valid/ready            | k_value, current_on, quad_gradient
// csr_*   | in  | csr_wr_en, no back-pressure | step_length
//
// A table write is accepted in the idle state. An evaluation holds the input off while each
// table is swept one entry a cycle through its registered read port and the last read drains;
// longer when an undulator entry covers the position (taper product in four partials on the
// one 32x32 multiplier), and when a quad overlaps the window, longer again when the overlap
// is partial (overlap product, then a bit-serial divide by step_length), and until the
// result register is free.
// Synchronous active-high reset clears the valid bits and prev_k and sets step_length to 1.
// A waiting result does not stop the next transaction being taken in.
module lattice_segment_field_lookup
   import lsfl_pkg::*;
#(
   parameter int UND_ENTRIES  = UND_ENTRIES_DEF,
   parameter int QUAD_ENTRIES = QUAD_ENTRIES_DEF,
   parameter int POS_WIDTH    = POS_WIDTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   lsfl_req_if.sink    req_ch,
   lsfl_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int SPW    = (POS_WIDTH < 32) ? POS_WIDTH : 32;
   localparam int UIW    = (UND_ENTRIES > 1) ? $clog2(UND_ENTRIES) : 1;
   localparam int QIW    = (QUAD_ENTRIES > 1) ? $clog2(QUAD_ENTRIES) : 1;
   localparam int MAXN   = (UND_ENTRIES > QUAD_ENTRIES) ? UND_ENTRIES : QUAD_ENTRIES;
   localparam int CW     = $clog2(MAXN + 1);

   // tables
   logic [SPW-1:0]     und_start_mem      [UND_ENTRIES];
   logic [SPW-1:0]     und_end_mem        [UND_ENTRIES];
   logic [SPW-1:0]     und_cell_start_mem [UND_ENTRIES];
   logic [SPW-1:0]     und_cell_end_mem   [UND_ENTRIES];
   logic [31:0]        und_strength_mem   [UND_ENTRIES];
   logic [31:0]        und_taper_mem      [UND_ENTRIES];
   logic [1:0]         und_flags_mem      [UND_ENTRIES];
   logic [SPW-1:0]     quad_start_mem     [QUAD_ENTRIES];
   logic [SPW-1:0]     quad_end_mem       [QUAD_ENTRIES];
   logic [31:0]        quad_strength_mem  [QUAD_ENTRIES];
   logic [UND_ENTRIES-1:0]  und_valid_ff;
   logic [QUAD_ENTRIES-1:0] quad_valid_ff;

   state_type state_ff, state_in;

   logic        accept;
   logic        und_we, quad_we;
   logic [7:0]  idx8;
   logic [UIW-1:0] uw_addr, ur_addr;
   logic [QIW-1:0] qw_addr, qr_addr;

   logic [15:0] step_length_ff;
   logic [31:0] prev_k_ff;
   logic [CW-1:0] cnt_ff;
   logic [4:0]  step_ff;
   logic        cnt_end;

   // read stage
   logic [SPW-1:0] u_start_ff, u_end_ff, u_cstart_ff, u_cend_ff;
   logic [31:0]    u_str_ff, u_tp_ff;
   logic [1:0]     u_flags_ff;
   logic           u_rv_ff;
   logic [SPW-1:0] q_start_ff, q_end_ff;
   logic [31:0]    q_str_ff;
   logic           q_rv_ff;

   // working registers
   logic [23:0]   step_cnt_ff;
   logic          half_ff;
   logic [ZW-1:0] z2_ff, x1_ff;
   logic          hit_ff, nocur_ff, air_ff;
   logic [31:0]   k0_ff, tp_ff;
   logic [ZW-1:0] d2_ff;
   logic [63:0]   mag_ff;
   logic          kneg_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [31:0]   kres_ff;
   logic          cur_ff;
   logic          qfound_ff;
   logic [ZW-1:0] q0_ff, q1_ff;
   logic [31:0]   g_ff;
   logic [15:0]   len_ff;
   logic [31:0]   div_q_ff;
   logic [15:0]   rem_ff;
   logic [31:0]   gres_ff;

   logic          rsp_valid_ff;
   logic [31:0]   rsp_k_ff, rsp_g_ff;
   logic          rsp_cur_ff;
   logic          rsp_load;

   // multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;

   lsfl_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod_ff)
   );

   assign accept  = req_ch.valid && req_ch.ready;
   assign idx8    = {4'b0000, req_ch.entry_index};
   assign uw_addr = idx8[UIW-1:0];
   assign qw_addr = idx8[QIW-1:0];
   assign und_we  = accept && (req_ch.opcode == OP_WR_UND)
                    && (int'(req_ch.entry_index) < UND_ENTRIES);
   assign quad_we = accept && (req_ch.opcode == OP_WR_QUAD)
                    && (int'(req_ch.entry_index) < QUAD_ENTRIES);
   assign ur_addr = cnt_ff[UIW-1:0];
   assign qr_addr = cnt_ff[QIW-1:0];

   assign req_ch.ready = (state_ff == ST_IDLE);

   // ---------------- table storage ----------------
   always_ff @(posedge clock) begin
      if (und_we) begin
         und_start_mem[uw_addr]      <= req_ch.seg_start[SPW-1:0];
         und_end_mem[uw_addr]        <= req_ch.seg_end[SPW-1:0];
         und_cell_start_mem[uw_addr] <= req_ch.cell_start[SPW-1:0];
         und_cell_end_mem[uw_addr]   <= req_ch.cell_end[SPW-1:0];
         und_strength_mem[uw_addr]   <= req_ch.strength;
         und_taper_mem[uw_addr]      <= req_ch.taper;
         und_flags_mem[uw_addr]      <= {req_ch.air_gap, req_ch.no_current};
      end
      if (quad_we) begin
         quad_start_mem[qw_addr]    <= req_ch.seg_start[SPW-1:0];
         quad_end_mem[qw_addr]      <= req_ch.seg_end[SPW-1:0];
         quad_strength_mem[qw_addr] <= req_ch.strength;
      end
      u_start_ff  <= und_start_mem[ur_addr];
      u_end_ff    <= und_end_mem[ur_addr];
      u_cstart_ff <= und_cell_start_mem[ur_addr];
      u_cend_ff   <= und_cell_end_mem[ur_addr];
      u_str_ff    <= und_strength_mem[ur_addr];
      u_tp_ff     <= und_taper_mem[ur_addr];
      u_flags_ff  <= und_flags_mem[ur_addr];
      q_start_ff  <= quad_start_mem[qr_addr];
      q_end_ff    <= quad_end_mem[qr_addr];
      q_str_ff    <= quad_strength_mem[qr_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         und_valid_ff  <= '0;
         quad_valid_ff <= '0;
      end else begin
         if (und_we) begin
            und_valid_ff[uw_addr] <= 1'b1;
         end
         if (quad_we) begin
            quad_valid_ff[qw_addr] <= 1'b1;
         end
      end
   end

   // ---------------- scan compare ----------------
   logic [ZW-1:0] u_s2, u_e2, u_cs2, u_ce2, q_q0, q_q1;
   logic          u_cov, u_air, q_hit;

   assign u_s2  = dbl(32'(u_start_ff));
   assign u_e2  = dbl(32'(u_end_ff));
   assign u_cs2 = dbl(32'(u_cstart_ff));
   assign u_ce2 = dbl(32'(u_cend_ff));
   assign q_q0  = dbl(32'(q_start_ff));
   assign q_q1  = dbl(32'(q_end_ff));

   assign u_cov = u_rv_ff && (z2_ff >= u_s2) && (z2_ff < u_e2);
   assign u_air = u_rv_ff && !u_cov && (z2_ff >= u_cs2) && (z2_ff < u_ce2)
                  && u_flags_ff[FLAG_AIR];
   assign q_hit = q_rv_ff && !qfound_ff && !((q_q1 <= z2_ff) || (q_q0 >= x1_ff));

   assign cnt_end = (cnt_ff == CW'(MAXN)) ||
                    ((state_ff == ST_USCAN) && (int'(cnt_ff) >= UND_ENTRIES)) ||
                    ((state_ff == ST_QSCAN) && (int'(cnt_ff) >= QUAD_ENTRIES));

   // ---------------- taper finish ----------------
   logic [64:0]        q_hi;
   logic [40:0]        q_cl;
   logic signed [42:0] k_sum;
   logic [31:0]        k_sat, k_fin;

   assign q_hi = acc_ff[ACC_W-1:TAPER_SH];
   assign q_cl = (q_hi > (65'd1 << 40)) ? (41'd1 << 40) : q_hi[40:0];

   always_comb begin
      k_sum = 43'(signed'(k0_ff)) + (kneg_ff ? -signed'({2'b00, q_cl})
                                            : signed'({2'b00, q_cl}));
      if (k_sum > 43'sd2147483647) begin
         k_sat = 32'h7FFF_FFFF;
      end else if (k_sum < -43'sd2147483648) begin
         k_sat = 32'h8000_0000;
      end else begin
         k_sat = k_sum[31:0];
      end
      if (air_ff) begin
         k_fin = '0;
      end else if (hit_ff) begin
         k_fin = k_sat;
      end else begin
         k_fin = prev_k_ff;
      end
   end

   // ---------------- overlap length ----------------
   logic        ov_partial;
   logic [ZW-1:0] ov_len;

   always_comb begin
      ov_partial = 1'b1;
      if ((z2_ff < q0_ff) && (q1_ff < x1_ff)) begin
         ov_len = q1_ff - q0_ff;
      end else if ((z2_ff < q0_ff) && (q0_ff < x1_ff)) begin
         ov_len = x1_ff - q0_ff;
      end else if ((z2_ff < q1_ff) && (q1_ff < x1_ff)) begin
         ov_len = q1_ff - z2_ff;
      end else begin
         ov_partial = 1'b0;
         ov_len     = '0;
      end
   end

   // ---------------- divider step ----------------
   logic [16:0] div_r2, div_diff;
   logic        div_ge;

   assign div_r2   = {rem_ff, div_q_ff[31]};
   assign div_ge   = div_r2 >= {1'b0, step_length_ff};
   assign div_diff = div_r2 - {1'b0, step_length_ff};

   // ---------------- multiplier operands ----------------
   logic [1:0] pidx;
   logic [1:0] psh;

   assign pidx = step_ff[2:1];
   assign psh  = 2'(pidx[0]) + 2'(pidx[1]);

   always_comb begin
      case (state_ff)
         ST_ZMUL: begin
            mul_a = {7'd0, step_cnt_ff, half_ff};
            mul_b = {16'd0, step_length_ff};
         end
         ST_KMAG: begin
            mul_a = mag32(k0_ff);
            mul_b = mag32(tp_ff);
         end
         ST_KPP: begin
            mul_a = pidx[1] ? mag_ff[63:32] : mag_ff[31:0];
            mul_b = pidx[0] ? {22'd0, d2_ff[ZW-1:32]} : d2_ff[31:0];
         end
         ST_GMUL: begin
            mul_a = mag32(g_ff);
            mul_b = {16'd0, len_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_ch.opcode == OP_EVAL)) begin
               state_in = ST_ZMUL;
            end
         end
         ST_ZMUL:    state_in = ST_ZCAP;
         ST_ZCAP:    state_in = ST_USCAN;
         ST_USCAN: begin
            if (cnt_end) begin
               state_in = (hit_ff || u_cov) ? ST_KMAG : ST_KFIN;
            end
         end
         ST_KMAG:    state_in = ST_KMAGCAP;
         ST_KMAGCAP: state_in = ST_KPP;
         ST_KPP: begin
            if (step_ff == 5'd7) begin
               state_in = ST_KFIN;
            end
         end
         ST_KFIN:    state_in = ST_QSCAN;
         ST_QSCAN: begin
            if (cnt_end) begin
               state_in = (qfound_ff || q_hit) ? ST_QLEN : ST_DONE;
            end
         end
         ST_QLEN: begin
            state_in = (ov_partial && (step_length_ff != 16'd0)) ? ST_GMUL : ST_DONE;
         end
         ST_GMUL:    state_in = ST_GCAP;
         ST_GCAP:    state_in = ST_GDIV;
         ST_GDIV: begin
            if (step_ff == 5'd31) begin
               state_in = ST_GSIGN;
            end
         end
         ST_GSIGN:   state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_length_ff <= 16'd1;
         prev_k_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         u_rv_ff        <= 1'b0;
         q_rv_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            step_length_ff <= csr_wr_data;
         end
         if (state_ff == ST_KFIN) begin
            prev_k_ff <= k_fin;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // entry read this cycle is live only inside the table and when written
         u_rv_ff <= (state_ff == ST_USCAN) && (int'(cnt_ff) < UND_ENTRIES)
                    && und_valid_ff[ur_addr];
         q_rv_ff <= (state_ff == ST_QSCAN) && (int'(cnt_ff) < QUAD_ENTRIES)
                    && quad_valid_ff[qr_addr];
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            step_cnt_ff <= req_ch.step_count;
            half_ff     <= req_ch.half_step;
         end
         ST_ZCAP: begin
            // hold doubled position and window end
            z2_ff     <= prod_ff[ZW-1:0];
            x1_ff     <= prod_ff[ZW-1:0] + ZW'(step_length_ff);
            cnt_ff    <= '0;
            hit_ff    <= 1'b0;
            nocur_ff  <= 1'b0;
            air_ff    <= 1'b0;
         end
         ST_USCAN: begin
            cnt_ff <= cnt_ff + CW'(1);
            if (u_cov) begin
               // last covering entry wins
               hit_ff <= 1'b1;
               k0_ff  <= u_str_ff;
               tp_ff  <= u_tp_ff;
               d2_ff  <= z2_ff - u_s2;
               if (u_flags_ff[FLAG_NOCUR]) begin
                  nocur_ff <= 1'b1;
               end
            end
            if (u_air) begin
               air_ff <= 1'b1;
            end
         end
         ST_KMAG: begin
            kneg_ff <= k0_ff[31] ^ tp_ff[31];
         end
         ST_KMAGCAP: begin
            mag_ff  <= prod_ff;
            acc_ff  <= '0;
            step_ff <= '0;
         end
         ST_KPP: begin
            step_ff <= step_ff + 5'd1;
            // odd cycles add the partial issued on the previous cycle
            if (step_ff[0]) begin
               acc_ff <= acc_ff + (ACC_W'(prod_ff) << (32 * int'(psh)));
            end
         end
         ST_KFIN: begin
            kres_ff   <= k_fin;
            cur_ff    <= hit_ff && !nocur_ff;
            cnt_ff    <= '0;
            qfound_ff <= 1'b0;
            gres_ff   <= '0;
         end
         ST_QSCAN: begin
            cnt_ff <= cnt_ff + CW'(1);
            if (q_hit) begin
               // first overlapping quad only
               qfound_ff <= 1'b1;
               q0_ff     <= q_q0;
               q1_ff     <= q_q1;
               g_ff      <= q_str_ff;
            end
         end
         ST_QLEN: begin
            len_ff  <= ov_len[15:0];
            gres_ff <= g_ff;
         end
         ST_GCAP: begin
            div_q_ff <= prod_ff[31:0];
            rem_ff   <= prod_ff[47:32];
            step_ff  <= '0;
         end
         ST_GDIV: begin
            step_ff  <= step_ff + 5'd1;
            rem_ff   <= div_ge ? div_diff[15:0] : div_r2[15:0];
            div_q_ff <= {div_q_ff[30:0], div_ge};
         end
         ST_GSIGN: begin
            gres_ff <= g_ff[31] ? (~div_q_ff + 32'd1) : div_q_ff;
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_k_ff   <= kres_ff;
         rsp_cur_ff <= cur_ff;
         rsp_g_ff   <= gres_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.k_value       = rsp_k_ff;
   assign rsp_ch.current_on    = rsp_cur_ff;
   assign rsp_ch.quad_gradient = rsp_g_ff;

   // ---------------- checks ----------------
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside completion");

   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.opcode == OP_EVAL) |=> state_ff == ST_ZMUL)
      else $error("evaluation transaction did not start");

   a_len_needs_quad: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QLEN |-> qfound_ff)
      else $error("overlap length without a quad hit");

   a_prev_k_held: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_KFIN |=> $stable(prev_k_ff))
      else $error("held strength changed outside finish");

endmodule
